FILE: hw/rtl/window_deviation_report_filter_assert.svh
// Assertion macros for the report filter.
`ifndef WINDOW_DEVIATION_REPORT_FILTER_ASSERT_SVH
`define WINDOW_DEVIATION_REPORT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define WDRF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define WDRF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WDRF_ASSERT(lbl, prop, msg)
`define WDRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/wdrf_pkg.sv
package wdrf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DIGIT_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic        ACTION_TICK       = 1'b1;
   localparam logic [6:0]  RST_WINDOW_LEN    = 7'd64;
   localparam logic [3:0]  RST_TOLERANCE     = 4'd2;
   localparam logic [31:0] RST_MIN_INTERVAL  = 32'd60000;
   localparam logic        RST_BOUND_MODE    = 1'b0;
   localparam logic signed [15:0] RST_LOWER  = -16'sd32768;
   localparam logic signed [15:0] RST_UPPER  = 16'sd32767;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LAUNCH, ST_WAIT, ST_UPDATE, ST_DIFF, ST_DECIDE
   } state_type;

   typedef enum logic [2:0] {
      OP_VSQ, OP_OSQ, OP_NV, OP_NQ, OP_SS, OP_DD, OP_KD
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LEN   = 3'd0,
      CSR_TOLERANCE    = 3'd1,
      CSR_MIN_INTERVAL = 3'd2,
      CSR_BOUND_MODE   = 3'd3,
      CSR_LOWER_LIMIT  = 3'd4,
      CSR_UPPER_LIMIT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CAUSE_NONE, CAUSE_ABOVE, CAUSE_BELOW, CAUSE_INTERVAL
   } cause_type;

   function automatic logic [SAMPLE_W:0] abs17(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W:0] w;
      w = (SAMPLE_W+1)'(s);
      abs17 = w[SAMPLE_W] ? (SAMPLE_W+1)'(-w) : (SAMPLE_W+1)'(w);
   endfunction

endpackage

FILE: hw/rtl/wdrf_if.sv
interface wdrf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic signed [wdrf_pkg::SAMPLE_W-1:0] sample;
   modport source (output valid, action, sample, input ready);
   modport sink (input valid, action, sample, output ready);
endinterface

interface wdrf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 report;
   logic [1:0]                           cause;
   logic signed [wdrf_pkg::SAMPLE_W-1:0] value;
   modport source (output valid, report, cause, value, input ready);
   modport sink (input valid, report, cause, value, output ready);
endinterface

FILE: hw/rtl/window_deviation_report_filter.sv
// Report-by-exception filter over a sliding window of samples. A sample word (action 0) is
// pushed into a window of the last window_len samples and produces exactly one result word:
// report is set when the sample lies outside mean +/- tolerance * sigma of the window (sigma
// mode) or outside lower_limit..upper_limit (absolute mode), or when more than min_interval
// tick words (action 1) have passed since the last report. A tick word produces no result.
// The sigma test is exact integer math without a root, evaluated on one shared multiplier
// that takes one 16-bit digit of an operand per cycle. A sample uses seven products in
// sigma mode and only the squares of the new and the oldest sample in absolute mode.
// Writing window_len empties the window. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
`include "window_deviation_report_filter_assert.svh"
module window_deviation_report_filter #(
   parameter int MAX_WINDOW = 64
) (
   input  logic               clock,
   input  logic               reset,
   wdrf_req_if.sink           req_ch,
   wdrf_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [wdrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wdrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int NW    = $clog2(MAX_WINDOW + 1);     // fill count, n
   localparam int SLW   = $clog2(MAX_WINDOW);         // write slot
   localparam int SW    = 16 + NW;                    // signed window sum
   localparam int QW    = 32 + NW;                    // sum of squares
   localparam int DSW   = SW + 2;                     // signed n*v - S
   localparam int DMW   = DSW - 1;                    // |n*v - S|
   localparam int DDW   = 32 + 2 * NW;                // n*Q, S*S, their difference
   localparam int CMPW  = 40 + 2 * NW;                // d*d and k^2*D
   localparam int DGW   = wdrf_pkg::DIGIT_W;
   localparam int MAXD  = (DDW + DGW - 1) / DGW;
   localparam int AW    = DMW;
   localparam int XW    = MAXD * DGW;
   localparam int PW    = AW + XW;
   localparam int NDW   = $clog2(MAXD) + 1;
   localparam int ND_Q  = (QW + DGW - 1) / DGW;
   localparam int ND_S  = (SW + DGW - 1) / DGW;
   localparam int ND_D  = (DMW + DGW - 1) / DGW;

   // configuration
   logic [6:0]         len_ff;
   logic [3:0]         tol_ff;
   logic [31:0]        mint_ff;
   logic               mode_ff;
   logic signed [15:0] lo_ff, hi_ff;

   // window state
   logic signed [15:0]   mem [MAX_WINDOW];
   logic [SLW-1:0]       slot_ff, slot_in;
   logic [NW-1:0]        fill_ff, fill_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0]        sq_ff, sq_in;
   logic [31:0]          ticks_ff, ticks_in;

   // sequencer
   wdrf_pkg::state_type state_ff, state_in;
   wdrf_pkg::op_type    op_ff, op_in;

   // per-sample payload
   logic signed [15:0] v_ff, old_ff;
   logic [30:0]        vsq_ff, osq_ff;
   logic [SW-1:0]      nv_ff;
   logic [DDW-1:0]     nq_ff, ss_ff, dd_big_ff;
   logic [DMW-1:0]     dmag_ff;
   logic               dneg_ff, dzero_ff;
   logic [CMPW-1:0]    dd_ff, kd_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_report_ff;
   logic [1:0]         rsp_cause_ff;
   logic signed [15:0] rsp_value_ff;

   logic [NW-1:0]      alen;
   logic               full;
   logic               accept, tick_accept, out_load, mul_start, mul_done;
   logic [AW-1:0]      mul_a;
   logic [XW-1:0]      mul_x;
   logic [NDW-1:0]     mul_nd;
   logic [PW-1:0]      mul_prod;
   logic [16:0]        vmag, omag;
   logic [SW-1:0]      smag;
   logic [7:0]         k2;
   logic signed [DSW-1:0] nv_s, d_c;
   wdrf_pkg::cause_type cause_c, sig_cause;

   // active window length: zero acts as one, oversize clamps to MAX_WINDOW
   always_comb begin
      if (len_ff == '0)
         alen = NW'(1);
      else if (32'(len_ff) > 32'(MAX_WINDOW))
         alen = NW'(MAX_WINDOW);
      else
         alen = NW'(len_ff);
   end

   assign full = (fill_ff >= alen);
   assign vmag = wdrf_pkg::abs17(v_ff);
   assign omag = wdrf_pkg::abs17(old_ff);
   assign smag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign k2   = 8'(tol_ff) * 8'(tol_ff);

   // d = n*v - S, with n*v formed from |v| and given back its sign
   assign nv_s = v_ff[15] ? -$signed(DSW'({1'b0, nv_ff})) : $signed(DSW'({1'b0, nv_ff}));
   assign d_c  = nv_s - DSW'(sum_ff);

   // shared multiplier operands, one product per op
   always_comb begin
      mul_a  = '0;
      mul_x  = '0;
      mul_nd = NDW'(1);
      case (op_ff)
         wdrf_pkg::OP_VSQ: begin
            mul_a = AW'(vmag);
            mul_x = XW'(vmag);
         end
         wdrf_pkg::OP_OSQ: begin
            mul_a = AW'(omag);
            mul_x = XW'(omag);
         end
         wdrf_pkg::OP_NV: begin
            mul_a = AW'(fill_ff);
            mul_x = XW'(vmag);
         end
         wdrf_pkg::OP_NQ: begin
            mul_a  = AW'(fill_ff);
            mul_x  = XW'(sq_ff);
            mul_nd = NDW'(ND_Q);
         end
         wdrf_pkg::OP_SS: begin
            mul_a  = AW'(smag);
            mul_x  = XW'(smag);
            mul_nd = NDW'(ND_S);
         end
         wdrf_pkg::OP_DD: begin
            mul_a  = AW'(dmag_ff);
            mul_x  = XW'(dmag_ff);
            mul_nd = NDW'(ND_D);
         end
         wdrf_pkg::OP_KD: begin
            mul_a  = AW'(k2);
            mul_x  = XW'(dd_big_ff);
            mul_nd = NDW'(MAXD);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   wdrf_mul #(.AW(AW), .XW(XW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .x     (mul_x),
      .nd    (mul_nd),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // decision: above wins over below, which wins over interval elapsed
   always_comb begin
      sig_cause = wdrf_pkg::CAUSE_NONE;
      if (!dzero_ff && dd_ff > kd_ff)
         sig_cause = dneg_ff ? wdrf_pkg::CAUSE_BELOW : wdrf_pkg::CAUSE_ABOVE;
      if (mode_ff) begin
         if (v_ff > hi_ff)
            cause_c = wdrf_pkg::CAUSE_ABOVE;
         else if (v_ff < lo_ff)
            cause_c = wdrf_pkg::CAUSE_BELOW;
         else
            cause_c = wdrf_pkg::CAUSE_NONE;
      end else begin
         cause_c = sig_cause;
      end
      if (cause_c == wdrf_pkg::CAUSE_NONE && ticks_ff > mint_ff)
         cause_c = wdrf_pkg::CAUSE_INTERVAL;
   end

   // next state and next op
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         wdrf_pkg::ST_IDLE: begin
            if (req_ch.valid && req_ch.action != wdrf_pkg::ACTION_TICK) begin
               state_in = wdrf_pkg::ST_LAUNCH;
               op_in    = wdrf_pkg::OP_VSQ;
            end
         end
         wdrf_pkg::ST_LAUNCH: state_in = wdrf_pkg::ST_WAIT;
         wdrf_pkg::ST_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  wdrf_pkg::OP_VSQ: begin
                     op_in    = wdrf_pkg::OP_OSQ;
                     state_in = wdrf_pkg::ST_LAUNCH;
                  end
                  wdrf_pkg::OP_OSQ: state_in = wdrf_pkg::ST_UPDATE;
                  wdrf_pkg::OP_NV: begin
                     op_in    = wdrf_pkg::OP_NQ;
                     state_in = wdrf_pkg::ST_LAUNCH;
                  end
                  wdrf_pkg::OP_NQ: begin
                     op_in    = wdrf_pkg::OP_SS;
                     state_in = wdrf_pkg::ST_LAUNCH;
                  end
                  wdrf_pkg::OP_SS: state_in = wdrf_pkg::ST_DIFF;
                  wdrf_pkg::OP_DD: begin
                     op_in    = wdrf_pkg::OP_KD;
                     state_in = wdrf_pkg::ST_LAUNCH;
                  end
                  wdrf_pkg::OP_KD: state_in = wdrf_pkg::ST_DECIDE;
                  default: state_in = wdrf_pkg::ST_IDLE;
               endcase
            end
         end
         wdrf_pkg::ST_UPDATE: begin
            if (mode_ff) begin
               state_in = wdrf_pkg::ST_DECIDE;
            end else begin
               state_in = wdrf_pkg::ST_LAUNCH;
               op_in    = wdrf_pkg::OP_NV;
            end
         end
         wdrf_pkg::ST_DIFF: begin
            state_in = wdrf_pkg::ST_LAUNCH;
            op_in    = wdrf_pkg::OP_DD;
         end
         wdrf_pkg::ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_ch.ready)
               state_in = wdrf_pkg::ST_IDLE;
         end
         default: state_in = wdrf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = (state_ff == wdrf_pkg::ST_IDLE);
      mul_start    = (state_ff == wdrf_pkg::ST_LAUNCH);
      out_load     = (state_ff == wdrf_pkg::ST_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);
   end

   assign accept      = req_ch.valid && req_ch.ready;
   assign tick_accept = accept && (req_ch.action == wdrf_pkg::ACTION_TICK);

   // window update: drop the oldest sample once the window is full, add the new one
   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      if (state_ff == wdrf_pkg::ST_UPDATE) begin
         sum_in = sum_ff + SW'(v_ff) - (full ? SW'(old_ff) : SW'(0));
         sq_in  = sq_ff + QW'(vsq_ff) - (full ? QW'(osq_ff) : QW'(0));
         if (NW'(slot_ff) + NW'(1) >= alen)
            slot_in = '0;
         else
            slot_in = slot_ff + 1'b1;
         if (!full)
            fill_in = fill_ff + 1'b1;
      end
   end

   // tick count saturates; a report restarts it
   always_comb begin
      ticks_in = ticks_ff;
      if (tick_accept && ticks_ff != '1)
         ticks_in = ticks_ff + 1'b1;
      else if (out_load && cause_c != wdrf_pkg::CAUSE_NONE)
         ticks_in = '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wdrf_pkg::ST_IDLE;
         op_ff        <= wdrf_pkg::OP_VSQ;
         rsp_valid_ff <= 1'b0;
         len_ff       <= wdrf_pkg::RST_WINDOW_LEN;
         tol_ff       <= wdrf_pkg::RST_TOLERANCE;
         mint_ff      <= wdrf_pkg::RST_MIN_INTERVAL;
         mode_ff      <= wdrf_pkg::RST_BOUND_MODE;
         lo_ff        <= wdrf_pkg::RST_LOWER;
         hi_ff        <= wdrf_pkg::RST_UPPER;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         ticks_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         ticks_ff     <= ticks_in;
         if (csr_we) begin
            case (csr_index)
               wdrf_pkg::CSR_WINDOW_LEN: begin
                  // empty the window on any length write
                  len_ff  <= csr_wdata[6:0];
                  slot_ff <= '0;
                  fill_ff <= '0;
                  sum_ff  <= '0;
                  sq_ff   <= '0;
               end
               wdrf_pkg::CSR_TOLERANCE:    tol_ff  <= csr_wdata[3:0];
               wdrf_pkg::CSR_MIN_INTERVAL: mint_ff <= csr_wdata;
               wdrf_pkg::CSR_BOUND_MODE:   mode_ff <= csr_wdata[0];
               wdrf_pkg::CSR_LOWER_LIMIT:  lo_ff   <= $signed(csr_wdata[15:0]);
               wdrf_pkg::CSR_UPPER_LIMIT:  hi_ff   <= $signed(csr_wdata[15:0]);
               default: ;
            endcase
         end
      end
   end

   // window memory: registered read of the slot about to be overwritten
   always_ff @(posedge clock) begin
      old_ff <= mem[slot_ff];
      if (state_ff == wdrf_pkg::ST_UPDATE)
         mem[slot_ff] <= v_ff;
   end

   // payload: latch the sample, capture products, form d and D
   always_ff @(posedge clock) begin
      if (accept)
         v_ff <= req_ch.sample;
      if (state_ff == wdrf_pkg::ST_WAIT && mul_done) begin
         case (op_ff)
            wdrf_pkg::OP_VSQ: vsq_ff <= mul_prod[30:0];
            wdrf_pkg::OP_OSQ: osq_ff <= mul_prod[30:0];
            wdrf_pkg::OP_NV:  nv_ff  <= mul_prod[SW-1:0];
            wdrf_pkg::OP_NQ:  nq_ff  <= mul_prod[DDW-1:0];
            wdrf_pkg::OP_SS:  ss_ff  <= mul_prod[DDW-1:0];
            wdrf_pkg::OP_DD:  dd_ff  <= mul_prod[CMPW-1:0];
            wdrf_pkg::OP_KD:  kd_ff  <= mul_prod[CMPW-1:0];
            default: ;
         endcase
      end
      if (state_ff == wdrf_pkg::ST_DIFF) begin
         dneg_ff   <= d_c[DSW-1];
         dzero_ff  <= (d_c == '0);
         dmag_ff   <= d_c[DSW-1] ? DMW'(-d_c) : DMW'(d_c);
         dd_big_ff <= (nq_ff >= ss_ff) ? nq_ff - ss_ff : '0;
      end
      if (out_load) begin
         rsp_report_ff <= (cause_c != wdrf_pkg::CAUSE_NONE);
         rsp_cause_ff  <= cause_c;
         rsp_value_ff  <= v_ff;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.report = rsp_report_ff;
   assign rsp_ch.cause  = rsp_cause_ff;
   assign rsp_ch.value  = rsp_value_ff;

   `WDRF_ASSERT(a_fill_bound, fill_ff <= alen, "fill count beyond active window length")
   `WDRF_ASSERT(a_rsp_from_decide, $rose(rsp_valid_ff) |-> $past(out_load), "stray result")
   `WDRF_ASSERT(a_report_cause, rsp_valid_ff |-> rsp_report_ff == |rsp_cause_ff, "bad report")
   `WDRF_ASSERT(a_report_clears_ticks, (out_load && |cause_c) |=> ticks_ff == '0, "ticks kept")
   `WDRF_ASSERT_ALWAYS(a_done_in_wait, mul_done |-> state_ff == wdrf_pkg::ST_WAIT, "stray done")
endmodule

FILE: hw/rtl/wdrf_mul.sv
module wdrf_mul #(
   parameter int AW = 24,
   parameter int XW = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [AW-1:0]        a,
   input  logic [XW-1:0]        x,
   input  logic [$clog2(XW/wdrf_pkg::DIGIT_W):0] nd,
   output logic                 done,
   output logic [AW+XW-1:0]     prod
);
   localparam int DW = wdrf_pkg::DIGIT_W;
   localparam int ND = XW / DW;
   localparam int JW = (ND > 1) ? $clog2(ND) : 1;
   localparam int PW = AW + XW;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [JW-1:0] j_ff, j_in;
   logic [AW-1:0] a_ff;
   logic [XW-1:0] x_ff;
   logic [PW-1:0] acc_ff, acc_in;
   logic [DW-1:0] digit;
   logic [AW+DW-1:0] pp;

   assign digit = x_ff[j_ff*DW +: DW];
   assign pp    = a_ff * digit;

   // shift the partial sum up one digit and add the next digit product, top digit first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      j_in    = j_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         j_in    = JW'(nd - 1'b1);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DW) + PW'(pp);
         if (j_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            j_in = j_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= a;
         x_ff <= x;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
